// File: design/sfaf_pkg.sv
package sfaf_pkg;

   // Address widths and frame depth in bytes
   localparam int unsigned MAX_ADDR_W = 18;
   localparam int unsigned PTR_W      = 19;
   localparam int unsigned BEATS      = 6;

   // Three address bytes once max_address reaches this value
   localparam logic [MAX_ADDR_W-1:0] WIDE_ADDR_THRESHOLD = 18'd131071;
   localparam logic [MAX_ADDR_W-1:0] MAX_ADDR_RESET      = 18'h1FFF;

   // Memory opcodes
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_WRSR  = 8'h01;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_SLEEP = 8'hB9;
   localparam logic [7:0] DUMMY    = 8'h00;

   // Register map (index = byte address / 4)
   localparam logic CSR_MAX_ADDRESS   = 1'b0;
   localparam logic CSR_FENCE_ADDRESS = 1'b1;

   typedef enum logic [2:0] {
      KIND_READ         = 3'd0,
      KIND_WRITE        = 3'd1,
      KIND_READ_STATUS  = 3'd2,
      KIND_WRITE_STATUS = 3'd3,
      KIND_SLEEP        = 3'd4,
      KIND_WAKEUP       = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FENCE = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // One bus byte with its framing marks
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       capture;
   } beat_type;

   // Whole expansion of one request
   typedef struct packed {
      beat_type [BEATS-1:0] beats;
      logic [2:0]           count;
      status_type           status;
   } frame_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] value;
   } ptr_upd_type;

endpackage

// File: design/spi_fram_fenced_access_framer_top.sv
// Command framer for a serial FRAM on an SPI bus.
// req channel: one memory request per transfer. tuser carries the request
// kind (read byte, write byte, read status, write status, sleep, wakeup);
// tdata carries use_pointer, byte_address and write_value.
// rsp channel: one transfer per bus byte, in bus order, with marks for chip
// select release and read data capture; tuser holds the status, tlast marks
// the final byte of a request. A refused access gives a single transfer with
// a nonzero status and nothing for the bus.
// csr port: APB-style, max_address at 0x0 and fence_address at 0x4.
// The first byte of a request is offered in the cycle after its transfer.
// Throughput: one byte per cycle while the receiver accepts; a request expands
// into 0 to 6 bytes (spare kinds give none), held in the single frame register,
// and the next request is taken in the cycle its predecessor's last byte
// leaves, so requests flow back to back.
// Reset clears the current pointer and fence, sets max_address to 0x1FFF and
// empties the frame register. When the receiver stalls, the current byte is
// held and req_tready falls until the frame drains.
module spi_fram_fenced_access_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // use_pointer[0], byte_address[18:1], write_value[26:19]
   input  logic [2:0]  req_tuser,  // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // tx_byte[7:0], frame_end[8], capture[9]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sfaf_pkg::*;

   logic [MAX_ADDR_W-1:0] max_address_ff, max_address_in;
   logic [PTR_W-1:0]      fence_address_ff, fence_address_in;
   logic [PTR_W-1:0]      pointer_ff, pointer_in;
   logic                  csr_write;
   logic                  req_xfer;
   logic                  slot_free;
   logic                  busy;
   frame_type             frame;
   ptr_upd_type           ptr_upd;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_address_in   = max_address_ff;
      fence_address_in = fence_address_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_MAX_ADDRESS:   max_address_in   = csr_pwdata[MAX_ADDR_W-1:0];
            CSR_FENCE_ADDRESS: fence_address_in = csr_pwdata[PTR_W-1:0];
            default:           max_address_in   = max_address_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_MAX_ADDRESS:   csr_prdata = {14'd0, max_address_ff};
         CSR_FENCE_ADDRESS: csr_prdata = {13'd0, fence_address_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Current pointer advances as the request is taken
   assign req_tready = slot_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign pointer_in = (req_xfer && ptr_upd.en) ? ptr_upd.value : pointer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_address_ff   <= MAX_ADDR_RESET;
         fence_address_ff <= '0;
         pointer_ff       <= '0;
      end else begin
         max_address_ff   <= max_address_in;
         fence_address_ff <= fence_address_in;
         pointer_ff       <= pointer_in;
      end
   end

   sfaf_decode u_decode (
      .kind          (req_tuser),
      .use_pointer   (req_tdata[0]),
      .byte_address  (req_tdata[18:1]),
      .write_value   (req_tdata[26:19]),
      .pointer       (pointer_ff),
      .max_address   (max_address_ff),
      .fence_address (fence_address_ff),
      .frame         (frame),
      .ptr_upd       (ptr_upd)
   );

   sfaf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (req_xfer),
      .frame_in   (frame),
      .slot_free  (slot_free),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // An empty frame register always takes a request
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !busy |-> req_tready)
      else $error("request refused while frame register empty");

   // The pointer moves only with a request transfer
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(pointer_ff))
      else $error("current pointer changed without a request");

   // A refused access is a single, final transfer
   a_refuse_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> rsp_tlast)
      else $error("refused access not marked last");

   // Chip select release with capture only on the final read byte
   a_capture_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9]) |-> (rsp_tdata[8] && rsp_tlast))
      else $error("capture byte does not close the frame");
`endif

endmodule

// File: design/sfaf_decode.sv
module sfaf_decode (
   input  logic [2:0]                    kind,
   input  logic                          use_pointer,
   input  logic [sfaf_pkg::MAX_ADDR_W-1:0] byte_address,
   input  logic [7:0]                    write_value,
   input  logic [sfaf_pkg::PTR_W-1:0]    pointer,
   input  logic [sfaf_pkg::MAX_ADDR_W-1:0] max_address,
   input  logic [sfaf_pkg::PTR_W-1:0]    fence_address,
   output sfaf_pkg::frame_type           frame,
   output sfaf_pkg::ptr_upd_type         ptr_upd
);
   import sfaf_pkg::*;

   logic             wide;
   logic [PTR_W-1:0] max_ext;
   logic [PTR_W-1:0] eff_fence;
   logic [PTR_W-1:0] addr_sel;
   logic [PTR_W-1:0] addr;
   logic [PTR_W:0]   addr_next;
   logic [2:0]       k;

   function automatic beat_type make_beat(input logic [7:0] b, input logic fe,
                                          input logic cap);
      beat_type r;
      r.tx_byte   = b;
      r.frame_end = fe;
      r.capture   = cap;
      return r;
   endfunction

   // Effective fence and address selection
   assign wide      = (max_address >= WIDE_ADDR_THRESHOLD);
   assign max_ext   = {1'b0, max_address};
   assign eff_fence = (fence_address == '0 || fence_address > max_ext) ?
                      max_ext + PTR_W'(1) : fence_address;
   assign addr_sel  = use_pointer ? pointer : {1'b0, byte_address};
   assign addr      = (kind == KIND_WAKEUP) ? '0 : addr_sel;
   assign addr_next = {1'b0, addr} + (PTR_W+1)'(1);

   // Frame build
   always_comb begin
      frame         = '0;
      frame.status  = STATUS_OK;
      ptr_upd.en    = 1'b0;
      ptr_upd.value = (addr_next == {1'b0, eff_fence}) ? '0 : addr_next[PTR_W-1:0];
      k             = '0;
      case (req_kind_type'(kind))
         KIND_READ, KIND_WAKEUP: begin
            if (addr > max_ext) begin
               frame.status = STATUS_RANGE;
               k            = 3'd1;
            end else begin
               frame.beats[k] = make_beat(OP_READ, 1'b0, 1'b0);
               k = k + 3'd1;
               if (wide) begin
                  frame.beats[k] = make_beat({5'd0, addr[18:16]}, 1'b0, 1'b0);
                  k = k + 3'd1;
               end
               frame.beats[k] = make_beat(addr[15:8], 1'b0, 1'b0);
               k = k + 3'd1;
               frame.beats[k] = make_beat(addr[7:0], 1'b0, 1'b0);
               k = k + 3'd1;
               frame.beats[k] = make_beat(DUMMY, 1'b1, kind == KIND_READ);
               k = k + 3'd1;
               ptr_upd.en = (kind == KIND_READ);
            end
         end
         KIND_WRITE: begin
            if (addr >= eff_fence) begin
               frame.status = STATUS_FENCE;
               k            = 3'd1;
            end else begin
               frame.beats[k] = make_beat(OP_WREN, 1'b1, 1'b0);
               k = k + 3'd1;
               frame.beats[k] = make_beat(OP_WRITE, 1'b0, 1'b0);
               k = k + 3'd1;
               if (wide) begin
                  frame.beats[k] = make_beat({5'd0, addr[18:16]}, 1'b0, 1'b0);
                  k = k + 3'd1;
               end
               frame.beats[k] = make_beat(addr[15:8], 1'b0, 1'b0);
               k = k + 3'd1;
               frame.beats[k] = make_beat(addr[7:0], 1'b0, 1'b0);
               k = k + 3'd1;
               frame.beats[k] = make_beat(write_value, 1'b1, 1'b0);
               k = k + 3'd1;
               ptr_upd.en = 1'b1;
            end
         end
         KIND_READ_STATUS: begin
            frame.beats[0] = make_beat(OP_RDSR, 1'b0, 1'b0);
            frame.beats[1] = make_beat(DUMMY, 1'b1, 1'b1);
            k              = 3'd2;
         end
         KIND_WRITE_STATUS: begin
            frame.beats[0] = make_beat(OP_WREN, 1'b1, 1'b0);
            frame.beats[1] = make_beat(OP_WRSR, 1'b0, 1'b0);
            frame.beats[2] = make_beat(write_value, 1'b1, 1'b0);
            k              = 3'd3;
         end
         KIND_SLEEP: begin
            frame.beats[0] = make_beat(OP_SLEEP, 1'b1, 1'b0);
            k              = 3'd1;
         end
         default: begin
            k = '0;
         end
      endcase
      frame.count = k;
   end

endmodule

// File: design/sfaf_emit.sv
module sfaf_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfaf_pkg::frame_type frame_in,
   output logic                slot_free,
   output logic                busy,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,  // tx_byte[7:0], frame_end[8], capture[9], zero pad
   output logic [1:0]          rsp_tuser,  // status[1:0]
   output logic                rsp_tlast
);
   import sfaf_pkg::*;

   frame_type  frame_ff, frame_in_d;
   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   beat_type   beat;
   logic       last_beat;
   logic       xfer;

   assign frame_in_d = frame_in;
   assign beat       = frame_ff.beats[idx_ff];
   assign last_beat  = (idx_ff == frame_ff.count - 3'd1);
   assign xfer       = valid_ff && rsp_tready;
   // Next frame may enter as the final byte of the current one leaves
   assign slot_free  = !valid_ff || (xfer && last_beat);
   assign busy       = valid_ff;

   // Byte sequencing
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = (frame_in.count != '0);
         idx_in   = '0;
      end else if (xfer) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in_d;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, beat.capture, beat.frame_end, beat.tx_byte};
   assign rsp_tuser  = frame_ff.status;
   assign rsp_tlast  = last_beat;

endmodule

// File: tb/sv/spi_fram_fenced_access_framer_top_test.sv
`timescale 1ns / 100ps

module spi_fram_fenced_access_framer_top_test;
   import sfaf_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned ITEMS_PER_STEP = 45;
   localparam int unsigned SHOW_LIMIT     = 10;

   // Request kinds the block has no use for
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic        use_ptr;
      logic [17:0] addr;
      logic [7:0]  value;
   } fram_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       capture;
      logic [1:0] status;
      logic       last;
   } bus_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // use_pointer[0], byte_address[18:1], write_value[26:19]
   logic [2:0]  req_tuser = '0;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // tx_byte[7:0], frame_end[8], capture[9]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   spi_fram_fenced_access_framer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Shadow of the framer: limits, pointer and the bus bytes still owed
   logic [17:0]  fram_max   = MAX_ADDR_RESET;
   logic [18:0]  fram_fence = '0;
   logic [18:0]  fram_ptr   = '0;
   bus_byte_type bytes_due[$];
   fram_req_type requests_todo[$];

   int unsigned mismatch_count = 0;
   int unsigned requests_done  = 0;
   int unsigned bytes_seen     = 0;
   int unsigned refusals       = 0;
   int unsigned settings_used  = 1;

   // Handshake flags passed from the sampling edge to the driving edge
   logic        req_taken  = 1'b0;
   logic        req_loaded = 1'b0;
   logic        req_steady = 1'b0;
   int unsigned req_gap    = 0;
   logic        rsp_taken  = 1'b0;
   logic        rsp_steady = 1'b0;
   int unsigned rsp_hold   = 0;

   // Wrap point: register value, or max+1 when it is 0 or beyond max
   function automatic logic [18:0] wrap_point();
      if (fram_fence == '0 || fram_fence > {1'b0, fram_max})
         return {1'b0, fram_max} + 19'd1;
      return fram_fence;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic fe, input logic cap,
                             input status_type st, input logic last);
      bytes_due.push_back(bus_byte_type'{b, fe, cap, st, last});
   endtask

   // Two address bytes, three once max reaches the wide threshold
   task automatic queue_address(input logic [18:0] a);
      if (fram_max >= WIDE_ADDR_THRESHOLD)
         queue_byte({5'd0, a[18:16]}, 1'b0, 1'b0, STATUS_OK, 1'b0);
      queue_byte(a[15:8], 1'b0, 1'b0, STATUS_OK, 1'b0);
      queue_byte(a[7:0], 1'b0, 1'b0, STATUS_OK, 1'b0);
   endtask

   // Expand one request into the bus bytes it should produce
   task automatic frame_request(input fram_req_type rq);
      logic [18:0] a;
      logic [18:0] lim;
      a = rq.use_ptr ? fram_ptr : {1'b0, rq.addr};
      lim = wrap_point();
      case (rq.kind)
         KIND_READ, KIND_WAKEUP: begin
            if (rq.kind == KIND_WAKEUP)
               a = '0;
            if (a > {1'b0, fram_max}) begin
               queue_byte(8'h00, 1'b0, 1'b0, STATUS_RANGE, 1'b1);
               refusals++;
            end else begin
               queue_byte(OP_READ, 1'b0, 1'b0, STATUS_OK, 1'b0);
               queue_address(a);
               queue_byte(DUMMY, 1'b1, rq.kind == KIND_READ, STATUS_OK, 1'b1);
               // wakeup is a throwaway read; pointer stays put
               if (rq.kind == KIND_READ)
                  fram_ptr = (a + 19'd1 == lim) ? '0 : a + 19'd1;
            end
         end
         KIND_WRITE: begin
            if (a >= lim) begin
               queue_byte(8'h00, 1'b0, 1'b0, STATUS_FENCE, 1'b1);
               refusals++;
            end else begin
               queue_byte(OP_WREN, 1'b1, 1'b0, STATUS_OK, 1'b0);
               queue_byte(OP_WRITE, 1'b0, 1'b0, STATUS_OK, 1'b0);
               queue_address(a);
               queue_byte(rq.value, 1'b1, 1'b0, STATUS_OK, 1'b1);
               fram_ptr = (a + 19'd1 == lim) ? '0 : a + 19'd1;
            end
         end
         KIND_READ_STATUS: begin
            queue_byte(OP_RDSR, 1'b0, 1'b0, STATUS_OK, 1'b0);
            queue_byte(DUMMY, 1'b1, 1'b1, STATUS_OK, 1'b1);
         end
         KIND_WRITE_STATUS: begin
            queue_byte(OP_WREN, 1'b1, 1'b0, STATUS_OK, 1'b0);
            queue_byte(OP_WRSR, 1'b0, 1'b0, STATUS_OK, 1'b0);
            queue_byte(rq.value, 1'b1, 1'b0, STATUS_OK, 1'b1);
         end
         KIND_SLEEP: begin
            queue_byte(OP_SLEEP, 1'b1, 1'b0, STATUS_OK, 1'b1);
         end
         default: begin
            // spare kinds produce nothing
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input bus_byte_type want,
                                input bus_byte_type got);
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT) begin
         $display("%0t: %s: expected byte %h fe %b cap %b st %0d last %b",
                  $time, what, want.tx_byte, want.frame_end, want.capture, want.status,
                  want.last);
         $display("   got byte %h fe %b cap %b st %0d last %b",
                  got.tx_byte, got.frame_end, got.capture, got.status, got.last);
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      bus_byte_type got;
      bus_byte_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            frame_request(fram_req_type'{req_tuser, req_tdata[0], req_tdata[18:1],
                                         req_tdata[26:19]});
            req_taken = 1'b1;
            requests_done++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = bus_byte_type'{rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tuser,
                                 rsp_tlast};
            rsp_taken = 1'b1;
            bytes_seen++;
            if (bytes_due.size() == 0) begin
               note_mismatch("unexpected transfer", '0, got);
            end else begin
               want = bytes_due.pop_front();
               if (got !== want)
                  note_mismatch("wrong transfer", want, got);
            end
         end
      end
   end

   // Request driver: one item at a time, random gap after each transfer
   always @(negedge clock) begin
      fram_req_type nxt;
      if (req_taken) begin
         req_taken = 1'b0;
         req_loaded = 1'b0;
         req_gap = req_steady ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 19) == 0)
            req_steady = !req_steady;
      end
      if (!req_loaded && requests_todo.size() != 0) begin
         if (req_gap != 0) begin
            req_gap--;
         end else begin
            nxt = requests_todo.pop_front();
            req_tuser <= nxt.kind;
            req_tdata <= {5'd0, nxt.value, nxt.addr, nxt.use_ptr};
            req_loaded = 1'b1;
         end
      end
      req_tvalid <= req_loaded;
   end

   // Result side: random stall after each transfer, with stall-free stretches
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_hold = rsp_steady ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 24) == 0)
            rsp_steady = !rsp_steady;
      end
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog
   initial begin
      int unsigned n;
      for (n = 0; n < CYCLE_LIMIT; n++)
         @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic add_req(input logic [2:0] k, input logic p, input logic [17:0] a,
                          input logic [7:0] v);
      requests_todo.push_back(fram_req_type'{k, p, a, v});
   endtask

   // Mostly legal accesses near the limits, some wild addresses and spare kinds
   task automatic add_random_req();
      logic [2:0]  k;
      logic [17:0] a;
      logic [18:0] lim;
      int unsigned pick;
      lim = wrap_point();
      pick = $urandom_range(0, 99);
      if (pick < 30)      k = KIND_READ;
      else if (pick < 60) k = KIND_WRITE;
      else if (pick < 70) k = KIND_READ_STATUS;
      else if (pick < 78) k = KIND_WRITE_STATUS;
      else if (pick < 86) k = KIND_SLEEP;
      else if (pick < 96) k = KIND_WAKEUP;
      else                k = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
      case ($urandom_range(0, 5))
         0: a = 18'($urandom());
         1: a = 18'(fram_max - $urandom_range(0, 2));
         2: a = 18'(lim - 19'd1 - $urandom_range(0, 2));
         3: a = 18'(lim + $urandom_range(0, 1));
         default: a = 18'($urandom_range(0, fram_max));
      endcase
      add_req(k, $urandom_range(0, 99) < 40, a, 8'($urandom_range(0, 255)));
   endtask

   // Let everything drain, then let the block settle before touching registers
   task automatic wait_idle();
      while (requests_todo.size() != 0 || req_loaded || bytes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_MAX_ADDRESS)
         fram_max = value[17:0];
      else
         fram_fence = value[18:0];
   endtask

   task automatic set_limits(input logic [17:0] max_a, input logic [18:0] fence_a);
      wait_idle();
      csr_write(CSR_MAX_ADDRESS, {14'd0, max_a});
      csr_write(CSR_FENCE_ADDRESS, {13'd0, fence_a});
      settings_used++;
   endtask

   task automatic add_random_batch();
      int unsigned i;
      for (i = 0; i < ITEMS_PER_STEP; i++)
         add_random_req();
   endtask

   // Test sequence
   initial begin
      int unsigned r;
      logic [17:0] m;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limits: max 0x1FFF, wrap at 0x2000, two address bytes
      add_req(KIND_READ, 1'b0, 18'h00000, 8'h00);
      add_req(KIND_READ, 1'b0, 18'h01FFF, 8'h00);        // top address, pointer wraps
      add_req(KIND_READ, 1'b0, 18'h02000, 8'h00);        // just past max
      add_req(KIND_READ, 1'b0, 18'h3FFFF, 8'hFF);
      add_req(KIND_WRITE, 1'b0, 18'h00000, 8'hFF);
      add_req(KIND_WRITE, 1'b0, 18'h01FFF, 8'h00);       // last writable byte
      add_req(KIND_WRITE, 1'b0, 18'h02000, 8'h55);       // at the fence
      add_req(KIND_WRITE, 1'b0, 18'h3FFFF, 8'hFF);
      add_req(KIND_READ, 1'b1, 18'h3FFFF, 8'h00);        // pointer overrides address
      add_req(KIND_WRITE, 1'b1, 18'h00000, 8'h5A);
      add_req(KIND_READ_STATUS, 1'b0, 18'h00000, 8'h00);
      add_req(KIND_WRITE_STATUS, 1'b0, 18'h00000, 8'hA5);
      add_req(KIND_WRITE_STATUS, 1'b1, 18'h3FFFF, 8'h00);
      add_req(KIND_SLEEP, 1'b0, 18'h00000, 8'h00);
      add_req(KIND_WAKEUP, 1'b0, 18'h00000, 8'h00);
      add_req(KIND_WAKEUP, 1'b1, 18'h3FFFF, 8'hFF);
      add_req(KIND_SPARE_LO, 1'b0, 18'h00000, 8'h00);
      add_req(KIND_SPARE_HI, 1'b1, 18'h3FFFF, 8'hFF);
      add_random_batch();

      // Largest part, fence register above max
      set_limits(18'h3FFFF, 19'h40000);
      add_req(KIND_READ, 1'b0, 18'h3FFFF, 8'h00);
      add_req(KIND_WRITE, 1'b0, 18'h3FFFF, 8'h81);
      add_req(KIND_READ, 1'b0, 18'h20000, 8'h00);
      add_random_batch();

      // Single-byte part; a leftover pointer may now be out of range
      set_limits(18'h00000, 19'h00000);
      add_req(KIND_READ, 1'b1, 18'h00000, 8'h00);
      add_random_batch();

      // Wide threshold exactly, fence well below max
      set_limits(WIDE_ADDR_THRESHOLD, 19'd100);
      add_req(KIND_READ, 1'b0, 18'd150, 8'h00);          // past fence, no wrap
      add_req(KIND_WRITE, 1'b1, 18'd0, 8'h3C);           // pointer beyond fence
      add_random_batch();

      // One below the threshold: two address bytes, bit 16 dropped
      set_limits(WIDE_ADDR_THRESHOLD - 18'd1, {1'b0, WIDE_ADDR_THRESHOLD});
      add_random_batch();

      set_limits(18'd300, 19'd16);
      add_random_batch();

      // Random limits
      for (r = 0; r < 2; r++) begin
         m = ($urandom_range(0, 1) != 0) ? 18'($urandom_range(0, 600)) :
                                           18'($urandom_range(0, 18'h3FFFF));
         case ($urandom_range(0, 2))
            0: set_limits(m, 19'd0);
            1: set_limits(m, 19'($urandom_range(0, m)));
            default: set_limits(m, 19'($urandom_range(0, 19'h40000)));
         endcase
         add_random_batch();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests across %0d limit settings: %0d bus transfers checked,",
               requests_done, settings_used, bytes_seen);
      $display("%0d refused accesses, %0d mismatches", refusals, mismatch_count);
      if (mismatch_count == 0 && bytes_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: spi_fram_fenced_access_framer_top.f
design/sfaf_pkg.sv
design/sfaf_decode.sv
design/sfaf_emit.sv
design/spi_fram_fenced_access_framer_top.sv
tb/sv/spi_fram_fenced_access_framer_top_test.sv
